### sv/pch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pch_pkg
// Shared types and constants for the printable character histogram.
// ----------------------------------------------------------------------------
package pch_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int OUT_W           = 32;
    localparam int BIN_COUNT       = 95;
    localparam int BIN_IDX_W       = 7;

    localparam logic [7:0]           PRINT_LOW  = 8'd32;
    localparam logic [7:0]           PRINT_HIGH = 8'd126;
    localparam logic [BIN_IDX_W-1:0] BIN_LAST   = BIN_IDX_W'(BIN_COUNT - 1);

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_COMMIT = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic REPLY_SESSION = 1'b0;
    localparam logic REPLY_TOTAL   = 1'b1;

    typedef logic [BIN_IDX_W-1:0] t_bin_idx;

    typedef struct packed {
        logic     en;
        t_bin_idx idx;
    } t_bin_req;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WALK,
        ST_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_DATA,
        OP_COMMIT,
        OP_QUERY
    } t_op;

endpackage

### sv/printable_char_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printable_char_histogram_unit
// Session and global histograms of printable bytes, codes 32 to 126.
//
// Input channel (i_valid / o_stall): one request per accepted edge.
//   Data byte: one per cycle unless stalled, no reply; session bin is updated
//   by read-modify-write in the next cycle, forwarding between neighbors.
//   Query: reply passes through the request stage and the output register;
//   one query per cycle while the receiver keeps taking replies.
//   Commit: the session count reply takes the same path, then the input
//   stalls while the 95 bins are walked into the totals, one bin a cycle.
// Output channel (o_valid / i_stall): one output register; a stalled reply
// holds, and a query or commit waiting behind it holds the input stall.
// Reset (synchronous, active low) clears control state and all valid bits,
// so every bin reads zero at once; no clearing pass follows.
// ----------------------------------------------------------------------------
module printable_char_histogram_unit
    import pch_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_data_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_reply_kind,
    output logic [OUT_W-1:0]  o_count_value
);

    t_state                 r_state, n_state;
    t_op                    r_s1_op, n_s1_op;
    t_bin_idx               r_s1_bin;
    logic                   r_s1_zero;
    logic [COUNT_WIDTH-1:0] r_s1_cnt;
    logic [COUNT_WIDTH-1:0] r_sess_cnt, n_sess_cnt;
    logic                   r_last_en;
    t_bin_idx               r_last_bin;
    logic [COUNT_WIDTH-1:0] r_last_val;
    t_bin_idx               r_walk_idx;
    logic                   r_wk_wr_en;
    t_bin_idx               r_wk_wr_idx;
    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [COUNT_WIDTH-1:0] r_out_val;

    logic                   in_acc, in_print, out_free, s1_move;
    logic                   walk_rd, sess_clr, busy;
    t_bin_idx               in_bin;
    t_bin_req               sess_rd, sess_wr, tot_rd, tot_wr;
    logic [COUNT_WIDTH-1:0] sess_rd_data, tot_rd_data, sess_base, sess_wr_data, tot_wr_data;

    assign in_print = (i_data_byte >= PRINT_LOW) && (i_data_byte <= PRINT_HIGH);
    assign in_bin   = BIN_IDX_W'(i_data_byte - PRINT_LOW);
    assign out_free = !r_out_valid || !i_stall;
    assign s1_move  = ((r_s1_op == OP_QUERY) || (r_s1_op == OP_COMMIT)) && out_free;
    assign o_stall  = busy || (r_s1_op == OP_COMMIT) || ((r_s1_op == OP_QUERY) && !out_free);
    assign in_acc   = i_valid && !o_stall;

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (s1_move && (r_s1_op == OP_COMMIT)) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_walk_idx == BIN_LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_RUN;
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        walk_rd  = 1'b0;
        sess_clr = 1'b0;
        busy     = 1'b1;
        unique case (r_state)
            ST_RUN:   busy     = 1'b0;
            ST_WALK:  walk_rd  = 1'b1;
            ST_DRAIN: sess_clr = 1'b1;
            default:  busy     = 1'b1;
        endcase
    end

    // memory ports
    always_comb begin
        sess_rd.en  = walk_rd || (in_acc && (i_kind == KIND_DATA) && in_print);
        sess_rd.idx = walk_rd ? r_walk_idx : in_bin;
        tot_rd.en   = walk_rd || (in_acc && (i_kind == KIND_QUERY) && in_print);
        tot_rd.idx  = walk_rd ? r_walk_idx : in_bin;
        sess_wr.en  = (r_s1_op == OP_DATA);
        sess_wr.idx = r_s1_bin;
        tot_wr.en   = r_wk_wr_en;
        tot_wr.idx  = r_wk_wr_idx;
    end

    assign sess_base    = (r_last_en && (r_last_bin == r_s1_bin)) ? r_last_val : sess_rd_data;
    assign sess_wr_data = sess_base + COUNT_WIDTH'(1);
    assign tot_wr_data  = tot_rd_data + sess_rd_data;

    pch_bin_ram #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_sess_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (sess_rd),
        .o_rd_data (sess_rd_data),
        .i_wr      (sess_wr),
        .i_wr_data (sess_wr_data),
        .i_clr     (sess_clr)
    );

    pch_bin_ram #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tot_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (tot_rd),
        .o_rd_data (tot_rd_data),
        .i_wr      (tot_wr),
        .i_wr_data (tot_wr_data),
        .i_clr     (1'b0)
    );

    // request stage
    always_comb begin
        n_s1_op    = r_s1_op;
        n_sess_cnt = r_sess_cnt;
        if ((r_s1_op == OP_DATA) || s1_move) begin
            n_s1_op = OP_NONE;
        end
        if (in_acc) begin
            case (i_kind)
                KIND_DATA: begin
                    n_s1_op = in_print ? OP_DATA : OP_NONE;
                    if (in_print) begin
                        n_sess_cnt = r_sess_cnt + COUNT_WIDTH'(1);
                    end
                end
                KIND_COMMIT: begin
                    n_s1_op    = OP_COMMIT;
                    n_sess_cnt = '0;
                end
                KIND_QUERY: n_s1_op = OP_QUERY;
                default:    n_s1_op = OP_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_s1_op     <= OP_NONE;
            r_sess_cnt  <= '0;
            r_last_en   <= 1'b0;
            r_walk_idx  <= '0;
            r_wk_wr_en  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_op    <= n_s1_op;
            r_sess_cnt <= n_sess_cnt;
            r_last_en  <= sess_wr.en;
            r_wk_wr_en <= walk_rd;
            if (walk_rd) begin
                r_walk_idx <= (r_walk_idx == BIN_LAST) ? '0 : r_walk_idx + 1'b1;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_bin  <= in_bin;
            r_s1_zero <= !in_print;
            r_s1_cnt  <= r_sess_cnt;
        end
        r_last_bin  <= r_s1_bin;
        r_last_val  <= sess_wr_data;
        r_wk_wr_idx <= r_walk_idx;
        if (s1_move) begin
            r_out_kind <= (r_s1_op == OP_COMMIT) ? REPLY_SESSION : REPLY_TOTAL;
            if (r_s1_op == OP_COMMIT) begin
                r_out_val <= r_s1_cnt;
            end else begin
                r_out_val <= r_s1_zero ? '0 : tot_rd_data;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_reply_kind  = r_out_kind;
    assign o_count_value = OUT_W'(r_out_val);

endmodule

### sv/pch_bin_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pch_bin_ram
// One read, one write bin memory with registered read data. Per-entry valid
// bits make unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module pch_bin_ram
    import pch_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_bin_req               i_rd,
    output logic [COUNT_WIDTH-1:0] o_rd_data,
    input  t_bin_req               i_wr,
    input  logic [COUNT_WIDTH-1:0] i_wr_data,
    input  logic                   i_clr
);

    logic [COUNT_WIDTH-1:0] r_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]   r_vld;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr_data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_wr.en) begin
                r_vld[i_wr.idx] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_vld[i_rd.idx];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### sv/pch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pch_checker
// Port-level checks for the printable character histogram.
// ----------------------------------------------------------------------------
module pch_checker
    import pch_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             o_stall,
    input  logic [1:0]       i_kind,
    input  logic             o_valid,
    input  logic             i_stall,
    input  logic             o_reply_kind,
    input  logic [OUT_W-1:0] o_count_value
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("reply valid after reset");

    a_reply_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_count_value) && $stable(o_reply_kind)))
        else $error("stalled reply changed");

    a_commit_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_kind == KIND_COMMIT)) |=> o_stall)
        else $error("request taken right after commit");

    a_commit_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_kind == KIND_COMMIT)) |=> ##1 o_stall)
        else $error("request taken during bin walk");

endmodule

bind printable_char_histogram_unit pch_checker u_pch_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for printable_char_histogram_unit. Byte sessions,
// commits and total queries are driven through the request channel. A
// scoreboard model keeps the session bins, the global totals and the
// session count, and queues one expected reply per commit or query. Each
// reply taken from the block is checked in order against that queue. The
// run covers directed corner cases, four random phases (three of them with
// sender gaps or receiver stalls), and one long reply hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
    import pch_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 150;
    localparam int         MAX_REPORTS  = 10;
    localparam longint     TIMEOUT_NS   = 64'd6_000_000;

    typedef struct packed {
        logic             kind;
        logic [OUT_W-1:0] value;
    } t_reply;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic [1:0]       i_kind      = KIND_DATA;
    logic [7:0]       i_data_byte = 8'd0;
    logic             i_stall     = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic             o_reply_kind;
    logic [OUT_W-1:0] o_count_value;

    logic [COUNT_WIDTH_DEF-1:0] session_bins [BIN_COUNT];
    logic [COUNT_WIDTH_DEF-1:0] total_bins   [BIN_COUNT];
    logic [COUNT_WIDTH_DEF-1:0] session_count;
    t_reply                     pending_replies [$];

    int idle_pct       = 0;
    int stall_pct      = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int live_requests  = 0;
    int mismatch_count = 0;

    printable_char_histogram_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_reply_kind  (o_reply_kind),
        .o_count_value (o_count_value)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Returns 1 when the request changes state or produces a reply.
    function automatic bit histogram_apply(input logic [1:0] kind, input logic [7:0] code);
        t_reply   reply;
        bit       printable;
        t_bin_idx bin;
        printable = (code >= PRINT_LOW) && (code <= PRINT_HIGH);
        bin       = BIN_IDX_W'(code - PRINT_LOW);
        case (kind)
            KIND_DATA: begin
                if (!printable) return 1'b0;
                session_count = session_count + 1'b1;
                session_bins[bin] = session_bins[bin] + 1'b1;
                return 1'b1;
            end
            KIND_COMMIT: begin
                reply = '{kind: REPLY_SESSION, value: OUT_W'(session_count)};
                pending_replies.push_back(reply);
                for (int i = 0; i < BIN_COUNT; i++) begin
                    total_bins[i]   = total_bins[i] + session_bins[i];
                    session_bins[i] = '0;
                end
                session_count = '0;
                return 1'b1;
            end
            KIND_QUERY: begin
                reply.kind  = REPLY_TOTAL;
                reply.value = printable ? OUT_W'(total_bins[bin]) : '0;
                pending_replies.push_back(reply);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] session_byte();
        if ($urandom_range(99) < 85) return 8'($urandom_range(PRINT_HIGH, PRINT_LOW));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] query_code();
        if ($urandom_range(99) < 85) return 8'($urandom_range(PRINT_HIGH, PRINT_LOW));
        return 8'($urandom_range(255));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_request(input logic [1:0] kind, input logic [7:0] code);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= code;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (histogram_apply(kind, code)) live_requests++;
        @(negedge i_clk);
    endtask

    task automatic idle_input();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void report_mismatch(input string what, input t_reply want,
                                            input t_reply got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s: expected kind %0d count %0d, got kind %0d count %0d",
                     $time, what, want.kind, want.value, got.kind, got.value);
    endfunction

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{kind: o_reply_kind, value: o_count_value};
            if (pending_replies.size() == 0) begin
                report_mismatch("reply with none pending", '0, got);
            end else begin
                want = pending_replies.pop_front();
                if (got.kind !== want.kind) report_mismatch("reply_kind", want, got);
                if (got.value !== want.value) report_mismatch("count_value", want, got);
            end
        end
    end

    task automatic test_directed_cases();
        idle_pct  = 0;
        stall_pct = 0;
        push_request(KIND_COMMIT, 8'd0);
        push_request(KIND_QUERY, PRINT_LOW);
        push_request(KIND_DATA, 8'd0);
        push_request(KIND_DATA, PRINT_LOW - 8'd1);
        push_request(KIND_DATA, PRINT_HIGH + 8'd1);
        push_request(KIND_DATA, 8'hFF);
        push_request(KIND_DATA, PRINT_LOW);
        push_request(KIND_DATA, PRINT_HIGH);
        push_request(KIND_DATA, PRINT_HIGH);
        push_request(KIND_DATA, 8'h41);
        push_request(KIND_UNUSED, 8'h41);
        push_request(KIND_UNUSED, 8'hFF);
        push_request(KIND_QUERY, PRINT_HIGH);
        push_request(KIND_COMMIT, 8'hFF);
        push_request(KIND_QUERY, PRINT_LOW);
        push_request(KIND_QUERY, PRINT_HIGH);
        push_request(KIND_QUERY, 8'h41);
        push_request(KIND_QUERY, PRINT_LOW - 8'd1);
        push_request(KIND_QUERY, PRINT_HIGH + 8'd1);
        push_request(KIND_QUERY, 8'd0);
        push_request(KIND_QUERY, 8'hFF);
        push_request(KIND_COMMIT, 8'h20);
        push_request(KIND_DATA, PRINT_HIGH);
        push_request(KIND_COMMIT, 8'h7E);
        push_request(KIND_QUERY, PRINT_HIGH);
    endtask

    // Mostly well-formed sessions: bytes, commit, then a few queries.
    task automatic test_random_traffic(input int budget, input int send_idle,
                                       input int recv_stall);
        int stop_at;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        stop_at   = live_requests + budget;
        while (live_requests < stop_at) begin
            if ($urandom_range(99) < 80) begin
                repeat ($urandom_range(12, 1)) push_request(KIND_DATA, session_byte());
                if ($urandom_range(9) == 0)
                    push_request(KIND_UNUSED, 8'($urandom_range(255)));
                push_request(KIND_COMMIT, 8'($urandom_range(255)));
                repeat ($urandom_range(4, 1)) push_request(KIND_QUERY, query_code());
            end else begin
                push_request(2'($urandom_range(3)), 8'($urandom_range(255)));
            end
        end
    endtask

    // Replies are held off for a long stretch while requests keep coming.
    task automatic test_reply_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        idle_input();
        @(posedge i_clk);
        hold_request = HOLD_CYCLES;
        @(negedge i_clk);
        repeat (16) push_request(KIND_DATA, session_byte());
        push_request(KIND_COMMIT, 8'($urandom_range(255)));
        repeat (30) push_request(KIND_QUERY, query_code());
        push_request(KIND_COMMIT, 8'($urandom_range(255)));
    endtask

    initial begin
        foreach (session_bins[i]) begin
            session_bins[i] = '0;
            total_bins[i]   = '0;
        end
        session_count = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic(120, 0, 0);
        test_random_traffic(120, 72, 0);
        test_reply_backpressure();
        test_random_traffic(120, 0, 72);
        test_random_traffic(120, 26, 26);
        idle_input();
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

### files.f
sv/pch_pkg.sv
sv/pch_bin_ram.sv
sv/printable_char_histogram_unit.sv
sv/pch_checker.sv
tb/sv/tb_top.sv
